### src/gdiff_pkg.sv
package gdiff_pkg;

	// Default build-time sizes.
	localparam int MAX_WIDTH_DEF   = 32;
	localparam int AMOUNT_BITS_DEF = 16;

	// Widths of the configuration port and of the fixed register fields.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int GRID_W_BITS = 6;
	localparam int GRID_H_BITS = 16;
	localparam int RATE_BITS   = 16;

	localparam logic [GRID_W_BITS-1:0] GRID_WIDTH_RESET  = 6'd32;
	localparam logic [GRID_H_BITS-1:0] GRID_HEIGHT_RESET = 16'd32;
	localparam logic [RATE_BITS-1:0]   FLOW_RATE_RESET   = 16'd8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_GRID_WIDTH  = 2'd0,
		CFG_GRID_HEIGHT = 2'd1,
		CFG_FLOW_RATE   = 2'd2
	} cfg_index_t;

	// Neighbour offsets in visiting order: left, right, up, down.
	localparam int DCOL [4] = '{-1, 1, 0, 0};
	localparam int DROW [4] = '{0, 0, -1, 1};
	localparam logic [1:0] NBR_DOWN = 2'd3;

	// Status of the divider towards its sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### src/gdiff_ram.sv
module gdiff_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/gdiff_div.sv
module gdiff_div #(
	parameter int WIDTH = gdiff_pkg::AMOUNT_BITS_DEF,
	parameter int DIV_W = gdiff_pkg::RATE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [WIDTH-1:0]      dividend,
	input  logic [DIV_W-1:0]      divisor,
	output gdiff_pkg::div_stat_t  stat,
	output logic [WIDTH-1:0]      quotient
);

	localparam int CNT_W = $clog2(WIDTH + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [WIDTH-1:0] num_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] den_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   diff;
	logic             fits;

	// One restoring step: bring down the next dividend bit and try the subtraction.
	assign shifted = {rem_q, num_q[WIDTH-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = ~diff[DIV_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(WIDTH);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= (divisor == '0) ? DIV_W'(1) : divisor;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[WIDTH-2:0], fits};
			rem_q <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign quotient  = num_q;

endmodule

### src/grid_liquid_diffusion_step_unit.sv
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: amount
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: new_amount, tlast: frame_end
// cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data (taken only when idle)
//
// Every input beat waits for the bit-serial divider that forms the cell's share, and each
// result it produces passes through the single read port of the share store, which is
// visited once for the cell's own share and once per neighbour. No new beat is taken
// until the sequencer is idle again, and the frame's final beat also flushes the last row.
// The reset is asynchronous and active low; it clears the sequencer, the position counters
// and the registers to their defaults. The stores need no clearing, as a frame only reads
// entries it has already written. A stalled output holds the sequencer only when a new
// result is ready to be loaded while the previous one has not been taken.
module grid_liquid_diffusion_step_unit #(
	parameter int MAX_WIDTH   = gdiff_pkg::MAX_WIDTH_DEF,
	parameter int AMOUNT_BITS = gdiff_pkg::AMOUNT_BITS_DEF,
	localparam int DATA_W     = ((AMOUNT_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [DATA_W-1:0]                 s_axis_tdata,   // amount
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [DATA_W-1:0]                 m_axis_tdata,   // new_amount
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gdiff_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [gdiff_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int SAW  = $clog2(2 * MAX_WIDTH);
	localparam int AW   = AMOUNT_BITS + 4;
	localparam int HB   = gdiff_pkg::GRID_H_BITS;
	localparam logic [2:0] LAST_STEP = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_RADDR,
		S_RDATA,
		S_OUT,
		S_WRITE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [gdiff_pkg::GRID_W_BITS-1:0] width_q;
	logic [HB-1:0]                     height_q;
	logic [gdiff_pkg::RATE_BITS-1:0]   rate_q;

	// Position of the next input cell.
	logic [CW-1:0] col_q;
	logic [HB-1:0] row_q;

	// Cell whose result is being formed.
	logic [CW-1:0]          cur_col_q;
	logic [HB-1:0]          cur_row_q;
	logic                   flush_q;
	logic [2:0]             step_q;
	logic signed [AW-1:0]   acc_q;
	logic [AMOUNT_BITS-1:0] own_share_q;
	logic [AMOUNT_BITS-1:0] amount_q;
	logic [AMOUNT_BITS-1:0] share_q;

	logic                   m_valid_q;
	logic [AMOUNT_BITS-1:0] out_amount_q;
	logic                   out_last_q;

	logic [CW-1:0] w_last;
	logic [HB-1:0] h_last;
	logic          last_col;
	logic          last_cell;
	logic          out_free;
	logic          in_beat;

	gdiff_pkg::div_stat_t   div_stat;
	logic                   div_start;
	logic [AMOUNT_BITS-1:0] div_quot;

	logic [1:0]             nbr_k;
	logic signed [CW+1:0]   nbr_col;
	logic signed [HB+1:0]   nbr_row;
	logic                   nbr_inside;
	logic [AMOUNT_BITS-1:0] nbr_share;

	logic                   store_we;
	logic [SAW-1:0]         share_waddr;
	logic [SAW-1:0]         share_raddr;
	logic [AMOUNT_BITS-1:0] share_rdata;
	logic [AMOUNT_BITS-1:0] pend_rdata;
	logic [AMOUNT_BITS-1:0] clamped;

	// The share store keeps two rows; the row's parity selects the half.
	function automatic logic [SAW-1:0] slot(input logic row_odd, input logic [CW-1:0] col);
		slot = SAW'(col) + (row_odd ? SAW'(MAX_WIDTH) : SAW'(0));
	endfunction

	// Effective last column and last row: a zero register acts as one, and a width beyond
	// the store is held to the store's size.
	always_comb begin
		if (width_q == '0) begin
			w_last = '0;
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_last = CW'(MAX_WIDTH - 1);
		end else begin
			w_last = CW'(width_q - 6'd1);
		end
		h_last = (height_q == '0) ? '0 : height_q - HB'(1);
	end

	assign last_col  = (col_q == w_last);
	assign last_cell = last_col && (row_q == h_last);
	assign out_free  = !m_valid_q || m_axis_tready;

	// Register writes are taken only between cells and win over an input beat offered in
	// the same cycle, so that the beat lands in the restarted frame.
	assign cfg_ready     = (state_q == S_IDLE);
	assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid;
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign div_start     = in_beat;

	gdiff_div #(
		.WIDTH (AMOUNT_BITS),
		.DIV_W (gdiff_pkg::RATE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (s_axis_tdata[AMOUNT_BITS-1:0]),
		.divisor  (rate_q),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	// Step 0 fetches the cell's own amount and share; steps 1 to 4 visit the neighbours
	// in table order. The neighbour below is the cell just divided, so it needs no fetch.
	assign nbr_k   = 2'(step_q - 3'd1);
	assign nbr_col = $signed({2'b00, cur_col_q}) + (CW + 2)'(gdiff_pkg::DCOL[nbr_k]);
	assign nbr_row = $signed({2'b00, cur_row_q}) + (HB + 2)'(gdiff_pkg::DROW[nbr_k]);
	assign nbr_inside = !nbr_col[CW+1] && (nbr_col[CW:0] <= {1'b0, w_last})
		&& !nbr_row[HB+1] && (nbr_row[HB:0] <= {1'b0, h_last});
	assign nbr_share = (nbr_k == gdiff_pkg::NBR_DOWN) ? share_q : share_rdata;

	assign share_raddr = (step_q == 3'd0) ? slot(cur_row_q[0], cur_col_q)
		: slot(nbr_row[0], nbr_col[CW-1:0]);
	assign share_waddr = slot(row_q[0], col_q);
	assign store_we    = (state_q == S_WRITE);

	gdiff_ram #(
		.WIDTH (AMOUNT_BITS),
		.DEPTH (2 * MAX_WIDTH)
	) u_share_rows (
		.clk   (clk),
		.we    (store_we),
		.waddr (share_waddr),
		.wdata (share_q),
		.raddr (share_raddr),
		.rdata (share_rdata)
	);

	gdiff_ram #(
		.WIDTH (AMOUNT_BITS),
		.DEPTH (MAX_WIDTH)
	) u_pending (
		.clk   (clk),
		.we    (store_we),
		.waddr (col_q),
		.wdata (amount_q),
		.raddr (cur_col_q),
		.rdata (pend_rdata)
	);

	// A negative total gives zero and one beyond the amount range gives the maximum.
	always_comb begin
		if (acc_q[AW-1]) begin
			clamped = '0;
		end else if (|acc_q[AW-2:AMOUNT_BITS]) begin
			clamped = '1;
		end else begin
			clamped = acc_q[AMOUNT_BITS-1:0];
		end
	end

	// Sequencer, position counters, configuration and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			width_q   <= gdiff_pkg::GRID_WIDTH_RESET;
			height_q  <= gdiff_pkg::GRID_HEIGHT_RESET;
			rate_q    <= gdiff_pkg::FLOW_RATE_RESET;
			col_q     <= '0;
			row_q     <= '0;
			flush_q   <= 1'b0;
			step_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						if (row_q != '0) begin
							flush_q <= 1'b0;
							step_q  <= '0;
							state_q <= S_RADDR;
						end else begin
							state_q <= S_WRITE;
						end
					end
				end
				S_RADDR: begin
					state_q <= S_RDATA;
				end
				S_RDATA: begin
					if (step_q == LAST_STEP) begin
						state_q <= S_OUT;
					end else begin
						step_q  <= step_q + 3'd1;
						state_q <= S_RADDR;
					end
				end
				S_OUT: begin
					if (out_free) begin
						if (!flush_q) begin
							state_q <= S_WRITE;
						end else if (cur_col_q == w_last) begin
							col_q   <= '0;
							row_q   <= '0;
							flush_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							step_q  <= '0;
							state_q <= S_RADDR;
						end
					end
				end
				S_WRITE: begin
					if (last_cell) begin
						flush_q <= 1'b1;
						step_q  <= '0;
						state_q <= S_RADDR;
					end else if (last_col) begin
						col_q   <= '0;
						row_q   <= row_q + HB'(1);
						state_q <= S_IDLE;
					end else begin
						col_q   <= col_q + CW'(1);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// A write to a defined register restarts the frame; an unused index is ignored.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					gdiff_pkg::CFG_GRID_WIDTH: begin
						width_q <= cfg_data[gdiff_pkg::GRID_W_BITS-1:0];
						col_q   <= '0;
						row_q   <= '0;
					end
					gdiff_pkg::CFG_GRID_HEIGHT: begin
						height_q <= cfg_data[HB-1:0];
						col_q    <= '0;
						row_q    <= '0;
					end
					gdiff_pkg::CFG_FLOW_RATE: begin
						rate_q <= cfg_data[gdiff_pkg::RATE_BITS-1:0];
						col_q  <= '0;
						row_q  <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_beat) begin
					amount_q <= s_axis_tdata[AMOUNT_BITS-1:0];
				end
			end
			S_DIV: begin
				if (div_stat.done) begin
					share_q   <= div_quot;
					cur_col_q <= col_q;
					cur_row_q <= row_q - HB'(1);
				end
			end
			S_RDATA: begin
				if (step_q == 3'd0) begin
					acc_q       <= $signed({4'b0000, pend_rdata});
					own_share_q <= share_rdata;
				end else if (nbr_inside) begin
					acc_q <= acc_q + $signed({4'b0000, nbr_share})
						- $signed({4'b0000, own_share_q});
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_amount_q <= clamped;
					out_last_q   <= flush_q && (cur_col_q == w_last);
					cur_col_q    <= cur_col_q + CW'(1);
				end
			end
			S_WRITE: begin
				if (last_cell) begin
					cur_col_q <= '0;
					cur_row_q <= row_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = DATA_W'(out_amount_q);
	assign m_axis_tlast  = out_last_q;

	// The divider is only running while the sequencer waits for it.
	a_div_idle_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !div_stat.busy)
		else $error("divider busy while input is accepted");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_position_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= w_last) && (row_q <= h_last))
		else $error("input position outside the grid");

endmodule

### tb/grid_liquid_diffusion_step_unit_tb.sv
module grid_liquid_diffusion_step_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gdiff_pkg::*;

	// Sizes of the instance under test; the stores below mirror them.
	localparam int MAXW   = MAX_WIDTH_DEF;
	localparam int AMT_W  = AMOUNT_BITS_DEF;
	localparam int DATA_W = ((AMT_W + 7) / 8) * 8;

	// Index that selects no register: the block must ignore such a write.
	localparam logic [CFG_INDEX_W-1:0] CFG_NO_REGISTER = 2'd3;

	// Cycles allowed after the last expected beat before a register write, so that a
	// cell that produced no result has finished its division.
	localparam int SETTLE_CYCLES = 40;
	// Cycles waited at the very end for stray beats.
	localparam int DRAIN_CYCLES  = 60;
	// A watchdog ends the run after this many cycles without any beat on any channel.
	localparam int WATCHDOG_LIMIT = 4000;
	// Length of the deliberate output hold-off and how often it comes round.
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_EVERY    = 150;
	// Rough number of cells to push through the block in total.
	localparam int TARGET_CELLS  = 360;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [DATA_W-1:0]      s_axis_tdata = '0;   // amount
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [DATA_W-1:0]      m_axis_tdata;        // new_amount
	logic                   m_axis_tlast;        // frame_end
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	grid_liquid_diffusion_step_unit #(
		.MAX_WIDTH   (MAXW),
		.AMOUNT_BITS (AMT_W)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------------------
	// Diffusion predictor. It keeps its own copy of the registers, the two rows of shares,
	// the row of amounts still waiting for its result and the raster position.
	// ------------------------------------------------------------------------------------
	typedef struct packed {
		logic [AMT_W-1:0] new_amount;
		logic             frame_end;
	} cell_result_t;

	logic [GRID_W_BITS-1:0] model_width;
	logic [GRID_H_BITS-1:0] model_height;
	logic [RATE_BITS-1:0]   model_rate;
	logic [AMT_W-1:0]       share_store [2*MAXW];
	logic [AMT_W-1:0]       waiting_amount [MAXW];
	int unsigned            next_col;
	int unsigned            next_row;

	// Results still owed by the block, oldest first.
	cell_result_t expected_cells [$];

	int errors;
	int cells_sent;
	int results_seen;
	int frames_done;
	int settings_used;

	function automatic int unsigned active_width();
		int unsigned w;
		w = model_width;
		if (w == 0)
			w = 1;
		if (w > MAXW)
			w = MAXW;
		return w;
	endfunction

	function automatic int unsigned active_height();
		return (model_height == 0) ? 1 : model_height;
	endfunction

	// Shares of even rows live in the lower half of the store, odd rows in the upper half.
	function automatic int unsigned share_slot(int unsigned row, int unsigned col);
		return (row % 2) * MAXW + (col % MAXW);
	endfunction

	// New amount of the cell at (row, col). The share of the cell beneath it is passed in,
	// since that cell is the one just arriving and is not in the store yet.
	function automatic logic [AMT_W-1:0] settle_cell(int unsigned row, int unsigned col,
			int unsigned w, int unsigned h, logic [AMT_W-1:0] below);
		longint acc;
		longint nc;
		longint nr;
		longint own_share;
		longint nb_share;
		own_share = share_store[share_slot(row, col)];
		acc = waiting_amount[col % MAXW];
		for (int k = 0; k < 4; k++) begin
			nc = longint'(col) + DCOL[k];
			nr = longint'(row) + DROW[k];
			if (nc < 0 || nr < 0 || nc >= w || nr >= h)
				continue;
			if (DROW[k] > 0)
				nb_share = below;
			else
				nb_share = share_store[share_slot(int'(nr), int'(nc))];
			acc += nb_share - own_share;
		end
		// The sum is clamped to the amount range on both sides.
		if (acc < 0)
			acc = 0;
		if (acc > (longint'(1) << AMT_W) - 1)
			acc = (longint'(1) << AMT_W) - 1;
		return acc[AMT_W-1:0];
	endfunction

	// Takes one accepted cell and queues every result that it releases.
	function automatic void diffuse_cell(logic [AMT_W-1:0] amount);
		int unsigned w;
		int unsigned h;
		int unsigned col;
		int unsigned row;
		logic [RATE_BITS-1:0] rate;
		logic [AMT_W-1:0] share;
		cell_result_t res;
		w = active_width();
		h = active_height();
		rate = (model_rate == 0) ? 1 : model_rate;
		col = (next_col >= w) ? w - 1 : next_col;
		row = (next_row >= h) ? h - 1 : next_row;
		share = amount / rate;

		// The cell directly above is now complete.
		if (row >= 1) begin
			res.new_amount = settle_cell(row - 1, col, w, h, share);
			res.frame_end = 1'b0;
			expected_cells.push_back(res);
		end
		share_store[share_slot(row, col)] = share;
		waiting_amount[col % MAXW] = amount;

		if (col == w - 1 && row == h - 1) begin
			// The last cell of the frame flushes the whole bottom row.
			for (int unsigned cc = 0; cc < w; cc++) begin
				res.new_amount = settle_cell(row, cc, w, h, '0);
				res.frame_end = (cc == w - 1);
				expected_cells.push_back(res);
			end
			next_col = 0;
			next_row = 0;
			frames_done++;
		end else if (col == w - 1) begin
			next_col = 0;
			next_row = row + 1;
		end else begin
			next_col = col + 1;
			next_row = row;
		end
	endfunction

	// A write to any real register abandons the frame in progress; an unused index does not.
	function automatic void apply_register(logic [CFG_INDEX_W-1:0] index,
			logic [CFG_DATA_W-1:0] value);
		case (cfg_index_t'(index))
			CFG_GRID_WIDTH: begin
				model_width = value[GRID_W_BITS-1:0];
			end
			CFG_GRID_HEIGHT: begin
				model_height = value[GRID_H_BITS-1:0];
			end
			CFG_FLOW_RATE: begin
				model_rate = value[RATE_BITS-1:0];
			end
			default: begin
				return;
			end
		endcase
		next_col = 0;
		next_row = 0;
	endfunction

	initial begin
		model_width  = GRID_WIDTH_RESET;
		model_height = GRID_HEIGHT_RESET;
		model_rate   = FLOW_RATE_RESET;
		next_col     = 0;
		next_row     = 0;
	end

	// ------------------------------------------------------------------------------------
	// Directed stimulus. Each row is either a register write or one cell. Rows with a
	// typed result only occur on a single-cell grid, where the new amount is the amount
	// itself and the beat always closes the frame.
	// ------------------------------------------------------------------------------------
	typedef enum logic {
		STEP_REG,
		STEP_CELL
	} step_kind_t;

	typedef struct packed {
		step_kind_t             kind;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  value;
		logic                   typed;
		logic [AMT_W-1:0]       typed_amount;
	} directed_step_t;

	localparam int DIRECTED_LEN = 41;
	localparam directed_step_t DIRECTED [DIRECTED_LEN] = '{
		// Defaults after reset: two cells of the top row, which release nothing.
		'{STEP_CELL, CFG_GRID_WIDTH,  16'h1234, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'hFFFF, 1'b0, 16'h0000},
		// Zero width, zero height and zero rate all act as one.
		'{STEP_REG,  CFG_GRID_WIDTH,  16'h0000, 1'b0, 16'h0000},
		'{STEP_REG,  CFG_GRID_HEIGHT, 16'h0000, 1'b0, 16'h0000},
		'{STEP_REG,  CFG_FLOW_RATE,   16'h0000, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'hFFFF, 1'b1, 16'hFFFF},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'h0000, 1'b1, 16'h0000},
		// Single cell with the largest rate.
		'{STEP_REG,  CFG_GRID_WIDTH,  16'h0001, 1'b0, 16'h0000},
		'{STEP_REG,  CFG_GRID_HEIGHT, 16'h0001, 1'b0, 16'h0000},
		'{STEP_REG,  CFG_FLOW_RATE,   16'hFFFF, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'hAAAA, 1'b1, 16'hAAAA},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'h5555, 1'b1, 16'h5555},
		// Three by three, rate one: an empty centre among full cells drives the sum
		// above the maximum, while the full cells beside it come to exactly zero.
		'{STEP_REG,  CFG_GRID_WIDTH,  16'h0003, 1'b0, 16'h0000},
		'{STEP_REG,  CFG_GRID_HEIGHT, 16'h0003, 1'b0, 16'h0000},
		'{STEP_REG,  CFG_FLOW_RATE,   16'h0001, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'hFFFF, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'hFFFF, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'hFFFF, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'hFFFF, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'h0000, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'hFFFF, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'hFFFF, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'hFFFF, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'hFFFF, 1'b0, 16'h0000},
		// A single row: nothing comes out until its final cell flushes it.
		'{STEP_REG,  CFG_GRID_WIDTH,  16'h0002, 1'b0, 16'h0000},
		'{STEP_REG,  CFG_GRID_HEIGHT, 16'h0001, 1'b0, 16'h0000},
		'{STEP_REG,  CFG_FLOW_RATE,   16'h0003, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'h0007, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'h0064, 1'b0, 16'h0000},
		// Four by four, left unfinished; a write to the unused index in the middle
		// must leave the frame running.
		'{STEP_REG,  CFG_GRID_WIDTH,  16'h0004, 1'b0, 16'h0000},
		'{STEP_REG,  CFG_GRID_HEIGHT, 16'h0004, 1'b0, 16'h0000},
		'{STEP_REG,  CFG_FLOW_RATE,   16'h0004, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'h0190, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'h0320, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'h0000, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'hFFFF, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'h000C, 1'b0, 16'h0000},
		'{STEP_REG,  CFG_NO_REGISTER, 16'hBEEF, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'h03E8, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'h07D0, 1'b0, 16'h0000},
		'{STEP_CELL, CFG_GRID_WIDTH,  16'h0BB8, 1'b0, 16'h0000}
	};

	// ------------------------------------------------------------------------------------
	// Input side: cells go out in bursts of random length with random gaps in between.
	// The valid is only lowered when a gap really follows, so that it is never lowered
	// and raised again in the same time step.
	// ------------------------------------------------------------------------------------
	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  value;
	} reg_write_t;

	reg_write_t reg_batch [$];
	int         burst_left = 0;
	bit         offering = 1'b0;

	task automatic offer_cell(input logic [AMT_W-1:0] amount, input logic typed,
			input logic [AMT_W-1:0] typed_amount);
		int gap;
		int n_before;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= DATA_W'(amount);
		offering = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		burst_left--;
		cells_sent++;

		n_before = expected_cells.size();
		diffuse_cell(amount);
		if (typed) begin
			while (expected_cells.size() > n_before)
				void'(expected_cells.pop_back());
			expected_cells.push_back('{typed_amount, 1'b1});
		end
	endtask

	// Brings the block to rest: stops offering, waits for every owed beat and then for
	// the divider of a cell that released nothing.
	task automatic settle_block();
		if (offering) begin
			s_axis_tvalid <= 1'b0;
			offering = 1'b0;
		end
		burst_left = 0;
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the batch back to back; the valid stays high between writes.
	task automatic write_regs();
		foreach (reg_batch[i]) begin
			cfg_valid <= 1'b1;
			cfg_index <= reg_batch[i].index;
			cfg_data  <= reg_batch[i].value;
			do
				@(posedge clk);
			while (!cfg_ready);
			apply_register(reg_batch[i].index, reg_batch[i].value);
		end
		cfg_valid <= 1'b0;
		reg_batch.delete();
		settings_used++;
	endtask

	function automatic logic [GRID_W_BITS-1:0] pick_width();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 6'd1;
			2:       return 6'd63;
			3:       return 6'd32;
			4:       return 6'($urandom_range(33, 62));
			default: return 6'($urandom_range(2, 8));
		endcase
	endfunction

	function automatic logic [GRID_H_BITS-1:0] pick_height();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 16'd1;
			2:       return 16'hFFFF;
			3:       return 16'($urandom_range(2, 65534));
			default: return 16'($urandom_range(2, 6));
		endcase
	endfunction

	function automatic logic [RATE_BITS-1:0] pick_rate();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 16'd1;
			2:       return 16'hFFFF;
			3:       return 16'($urandom());
			default: return 16'($urandom_range(2, 16));
		endcase
	endfunction

	function automatic logic [AMT_W-1:0] pick_amount();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return AMT_W'($urandom_range(0, 255));
			default: return AMT_W'($urandom());
		endcase
	endfunction

	initial begin : stimulus
		int i;
		int unsigned w;
		int unsigned h;
		longint frame_cells;
		longint n_cells;
		logic [CFG_DATA_W-1:0] width_data;

		errors        = 0;
		cells_sent    = 0;
		results_seen  = 0;
		frames_done   = 0;
		settings_used = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: consecutive register rows are written as one batch.
		i = 0;
		while (i < DIRECTED_LEN) begin
			if (DIRECTED[i].kind == STEP_REG) begin
				settle_block();
				while (i < DIRECTED_LEN && DIRECTED[i].kind == STEP_REG) begin
					reg_batch.push_back('{DIRECTED[i].index, DIRECTED[i].value});
					i++;
				end
				write_regs();
			end else begin
				offer_cell(DIRECTED[i].value[AMT_W-1:0], DIRECTED[i].typed,
					DIRECTED[i].typed_amount);
				i++;
			end
		end

		// Random part: each phase picks a fresh setting and mostly sends whole frames,
		// sometimes a piece of one that the next write abandons. The width register also
		// receives junk in its unused upper bits.
		while (cells_sent < TARGET_CELLS) begin
			settle_block();
			width_data = CFG_DATA_W'($urandom());
			width_data[GRID_W_BITS-1:0] = pick_width();
			reg_batch.push_back('{CFG_GRID_WIDTH, width_data});
			reg_batch.push_back('{CFG_GRID_HEIGHT, pick_height()});
			reg_batch.push_back('{CFG_FLOW_RATE, pick_rate()});
			reg_batch.shuffle();
			write_regs();

			w = active_width();
			h = active_height();
			frame_cells = longint'(w) * h;
			if (frame_cells <= 160 && $urandom_range(0, 7) != 0)
				n_cells = frame_cells;
			else
				n_cells = $urandom_range(1, (frame_cells < 100) ? int'(frame_cells) : 100);
			repeat (n_cells) offer_cell(pick_amount(), 1'b0, '0);
		end

		// Drain: nothing may be owed, and nothing more may turn up afterwards.
		if (offering)
			s_axis_tvalid <= 1'b0;
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d cells over %0d register settings, %0d full frames.",
			cells_sent, settings_used, frames_done);
		$display("Checked %0d result beats, %0d mismatches.", results_seen, errors);
		if (errors == 0 && expected_cells.size() == 0)
			$display("grid_liquid_diffusion_step_unit test passed");
		else
			$display("grid_liquid_diffusion_step_unit test failed");
		$finish;
	end

	// ------------------------------------------------------------------------------------
	// Output side: the ready follows a changing pattern, with stretches of no stalls at
	// all. Every so often, while cells are being offered, it holds off for a long stretch
	// so that the block fills up and stops taking input.
	// ------------------------------------------------------------------------------------
	typedef enum logic [1:0] {
		SINK_ALWAYS,
		SINK_HALF,
		SINK_SPARSE,
		SINK_PERIODIC
	} sink_mode_t;

	sink_mode_t  sink_mode = SINK_ALWAYS;
	int          sink_mode_left = 0;
	int unsigned sink_tick = 0;
	int          hold_left = 0;
	int          beats_taken = 0;
	int          next_hold_at = 60;

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			beats_taken++;
		sink_tick++;
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else if (beats_taken >= next_hold_at && s_axis_tvalid) begin
			m_axis_tready <= 1'b0;
			hold_left = HOLD_CYCLES - 1;
			next_hold_at = beats_taken + HOLD_EVERY;
		end else begin
			if (sink_mode_left == 0) begin
				sink_mode = sink_mode_t'($urandom_range(0, 3));
				sink_mode_left = $urandom_range(16, 96);
			end
			sink_mode_left--;
			case (sink_mode)
				SINK_ALWAYS: begin
					m_axis_tready <= 1'b1;
				end
				SINK_HALF: begin
					m_axis_tready <= $urandom_range(0, 1);
				end
				SINK_SPARSE: begin
					m_axis_tready <= ($urandom_range(0, 3) == 0);
				end
				default: begin
					m_axis_tready <= (sink_tick % 5) != 0;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------------------
	// Checker: each output beat is compared with the oldest owed result. Values are read
	// at the edge before any update of that edge takes effect.
	// ------------------------------------------------------------------------------------
	cell_result_t oldest;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (expected_cells.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, got new_amount %0d frame_end %0b",
					$time, m_axis_tdata[AMT_W-1:0], m_axis_tlast);
			end else begin
				oldest = expected_cells.pop_front();
				if (m_axis_tdata[AMT_W-1:0] !== oldest.new_amount) begin
					errors++;
					$display("%0t: new_amount mismatch, expected %0d, got %0d",
						$time, oldest.new_amount, m_axis_tdata[AMT_W-1:0]);
				end
				if (m_axis_tlast !== oldest.frame_end) begin
					errors++;
					$display("%0t: frame_end mismatch, expected %0b, got %0b",
						$time, oldest.frame_end, m_axis_tlast);
				end
			end
		end
	end

	// Watchdog: any beat on any channel counts as progress.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d results still owed",
				$time, idle_cycles, expected_cells.size());
			$display("grid_liquid_diffusion_step_unit test failed");
			$finish;
		end
	end

endmodule
